@@ design/hgp_pkg.sv @@
// hgp_pkg: shared types, widths and constants for the hex grid pick block.
// No dependencies; compile first.
package hgp_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CELL_BITS_DEF = 12;

   localparam int PTR_W   = 12;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 2;
   localparam int SCR_W   = 13;
   localparam int PITCH_W = 17;
   localparam int TRI_W   = 19;
   localparam int HP_W    = 18;
   localparam int DIV_DW  = 19;
   localparam int LIM_W   = 34;
   localparam int DX_W    = 22;
   localparam int SQ_W    = 2 * DX_W;
   localparam int D2_W    = SQ_W + 1;
   localparam int NCAND   = 9;

   localparam logic [CSR_W-1:0] RADIUS_RST = 16'd6554;
   localparam logic [CSR_W-1:0] GAP_RST    = 16'd328;
   localparam logic [SCR_W-1:0] SCREEN_RST = 13'd700;

   localparam longint SQRT3_Q30 = 64'sd1859775393;

   typedef enum logic [IDX_W-1:0] {
      REG_HEX_RADIUS    = 2'd0,
      REG_HEX_GAP       = 2'd1,
      REG_SCREEN_WIDTH  = 2'd2,
      REG_SCREEN_HEIGHT = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [TRI_W-1:0] tri_pitch;
      logic [HP_W-1:0]  row_pitch;
      logic [LIM_W-1:0] limit;
   } geo_type;

   typedef struct packed {
      logic pitch_zero;
      logic neg_x;
      logic neg_y;
   } div_sb_type;

   typedef struct packed {
      logic            hit;
      logic [D2_W-1:0] dsq;
   } cand_type;

   function automatic longint sqrt3_fix(input int frac);
      return (SQRT3_Q30 + (longint'(1) << (29 - frac))) >>> (30 - frac);
   endfunction

endpackage

@@ design/hgp_if.sv @@
// hgp_if: request and response channel interfaces for the hex grid pick block.
// Depends on hgp_pkg.
interface hgp_req_if;
   import hgp_pkg::*;
   logic             valid;
   logic             ready;
   logic [PTR_W-1:0] pointer_x;
   logic [PTR_W-1:0] pointer_y;
   modport source (output valid, output pointer_x, output pointer_y, input ready);
   modport sink (input valid, input pointer_x, input pointer_y, output ready);
endinterface

interface hgp_rsp_if #(parameter int CELL_BITS = hgp_pkg::CELL_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic signed [CELL_BITS-1:0] cell_col;
   logic signed [CELL_BITS-1:0] cell_row;
   modport source (output valid, output found, output cell_col, output cell_row, input ready);
   modport sink (input valid, input found, input cell_col, input cell_row, output ready);
endinterface

@@ design/hgp_div.sv @@
// hgp_div: two-lane pipelined restoring divider, one quotient bit per stage.
// Standalone; carries a sideband word alongside each transaction.
module hgp_div #(
   parameter int NW = 29,
   parameter int DW = 13,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num_a,
   input  logic [NW-1:0] in_num_b,
   input  logic [DW-1:0] den_a,
   input  logic [DW-1:0] den_b,
   input  logic [SW-1:0] in_sb,
   output logic          out_valid,
   output logic [NW-1:0] out_quo_a,
   output logic [NW-1:0] out_quo_b,
   output logic [DW-1:0] out_rem_a,
   output logic [DW-1:0] out_rem_b,
   output logic [SW-1:0] out_sb
);

   logic          valid_ff  [NW];
   logic [NW-1:0] word_a_ff [NW];
   logic [NW-1:0] word_b_ff [NW];
   logic [DW-1:0] rem_a_ff  [NW];
   logic [DW-1:0] rem_b_ff  [NW];
   logic [SW-1:0] sb_ff     [NW];

   function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nbit,
                                            input logic [DW-1:0] den);
      logic [DW:0] trial;
      logic [DW:0] diff;
      trial = {rem, nbit};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         return {1'b1, diff[DW-1:0]};
      end else begin
         return {1'b0, trial[DW-1:0]};
      end
   endfunction

   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_stage
         logic          src_valid;
         logic [NW-1:0] src_a;
         logic [NW-1:0] src_b;
         logic [DW-1:0] src_ra;
         logic [DW-1:0] src_rb;
         logic [SW-1:0] src_sb;
         logic [DW:0]   step_a_in;
         logic [DW:0]   step_b_in;

         if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_a     = in_num_a;
            assign src_b     = in_num_b;
            assign src_ra    = '0;
            assign src_rb    = '0;
            assign src_sb    = in_sb;
         end else begin : g_next
            assign src_valid = valid_ff[k-1];
            assign src_a     = word_a_ff[k-1];
            assign src_b     = word_b_ff[k-1];
            assign src_ra    = rem_a_ff[k-1];
            assign src_rb    = rem_b_ff[k-1];
            assign src_sb    = sb_ff[k-1];
         end

         assign step_a_in = div_step(src_ra, src_a[NW-1], den_a);
         assign step_b_in = div_step(src_rb, src_b[NW-1], den_b);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= src_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               word_a_ff[k] <= {src_a[NW-2:0], step_a_in[DW]};
               word_b_ff[k] <= {src_b[NW-2:0], step_b_in[DW]};
               rem_a_ff[k]  <= step_a_in[DW-1:0];
               rem_b_ff[k]  <= step_b_in[DW-1:0];
               sb_ff[k]     <= src_sb;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NW-1];
   assign out_quo_a = word_a_ff[NW-1];
   assign out_quo_b = word_b_ff[NW-1];
   assign out_rem_a = rem_a_ff[NW-1];
   assign out_rem_b = rem_b_ff[NW-1];
   assign out_sb    = sb_ff[NW-1];

endmodule

@@ design/hgp_cand.sv @@
// hgp_cand: forms the nine neighbor offsets, squares them and tests against the radius.
// Depends on hgp_pkg; three register stages.
module hgp_cand #(
   parameter int QN = 30
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [QN-1:0]                quo_x,
   input  logic [hgp_pkg::DIV_DW-1:0]   rem_x,
   input  logic [QN-1:0]                quo_y,
   input  logic [hgp_pkg::DIV_DW-1:0]   rem_y,
   input  hgp_pkg::div_sb_type          in_sb,
   input  hgp_pkg::geo_type             geo,
   output logic                         out_valid,
   output logic                         out_pz,
   output logic signed [QN:0]           out_col,
   output logic signed [QN:0]           out_row,
   output hgp_pkg::cand_type            out_cand [hgp_pkg::NCAND]
);
   import hgp_pkg::*;

   logic signed [QN:0]     col_in, row_in;
   logic signed [DX_W-1:0] dx_in  [3];
   logic signed [DX_W-1:0] dye_in [3];
   logic signed [DX_W-1:0] dyo_in [3];

   logic                   c_valid_ff, c_pz_ff;
   logic signed [QN:0]     c_col_ff, c_row_ff;
   logic signed [DX_W-1:0] c_dx_ff  [3];
   logic signed [DX_W-1:0] c_dye_ff [3];
   logic signed [DX_W-1:0] c_dyo_ff [3];

   logic [SQ_W-1:0]        dx2_in  [3];
   logic [SQ_W-1:0]        dye2_in [3];
   logic [SQ_W-1:0]        dyo2_in [3];

   logic                   d_valid_ff, d_pz_ff;
   logic signed [QN:0]     d_col_ff, d_row_ff;
   logic [SQ_W-1:0]        d_dx2_ff  [3];
   logic [SQ_W-1:0]        d_dye2_ff [3];
   logic [SQ_W-1:0]        d_dyo2_ff [3];

   cand_type               cand_in [NCAND];

   logic                   e_valid_ff, e_pz_ff;
   logic signed [QN:0]     e_col_ff, e_row_ff;
   cand_type               e_cand_ff [NCAND];

   always_comb begin
      logic signed [QN:0]     qx, qy;
      logic signed [DX_W-1:0] rx, ry, tp, hp, hp2, base_e, base_o;
      qx     = signed'({1'b0, quo_x});
      qy     = signed'({1'b0, quo_y});
      col_in = in_sb.neg_x ? -qx : qx;
      row_in = in_sb.neg_y ? -qy : qy;
      rx     = signed'(DX_W'(rem_x));
      ry     = signed'(DX_W'(rem_y));
      if (in_sb.neg_x) begin
         rx = -rx;
      end
      if (in_sb.neg_y) begin
         ry = -ry;
      end
      tp     = signed'(DX_W'(geo.tri_pitch));
      hp     = signed'(DX_W'(geo.row_pitch));
      hp2    = hp + hp;
      base_e = -(ry + ry);
      base_o = base_e + hp;
      dx_in[0]  = rx + tp;
      dx_in[1]  = rx;
      dx_in[2]  = rx - tp;
      dye_in[0] = base_e - hp2;
      dye_in[1] = base_e;
      dye_in[2] = base_e + hp2;
      dyo_in[0] = base_o - hp2;
      dyo_in[1] = base_o;
      dyo_in[2] = base_o + hp2;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dx2_in[i]  = SQ_W'($signed(c_dx_ff[i]) * $signed(c_dx_ff[i]));
         dye2_in[i] = SQ_W'($signed(c_dye_ff[i]) * $signed(c_dye_ff[i]));
         dyo2_in[i] = SQ_W'($signed(c_dyo_ff[i]) * $signed(c_dyo_ff[i]));
      end
   end

   always_comb begin
      logic odd;
      for (int c = 0; c < 3; c++) begin
         odd = (c == 1) ? d_col_ff[0] : ~d_col_ff[0];
         for (int r = 0; r < 3; r++) begin
            cand_in[3*c+r].dsq = {1'b0, d_dx2_ff[c]}
                               + {1'b0, (odd ? d_dyo2_ff[r] : d_dye2_ff[r])};
            cand_in[3*c+r].hit = cand_in[3*c+r].dsq < D2_W'(geo.limit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= in_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_pz_ff  <= in_sb.pitch_zero;
         c_col_ff <= col_in;
         c_row_ff <= row_in;
         c_dx_ff  <= dx_in;
         c_dye_ff <= dye_in;
         c_dyo_ff <= dyo_in;
         d_pz_ff   <= c_pz_ff;
         d_col_ff  <= c_col_ff;
         d_row_ff  <= c_row_ff;
         d_dx2_ff  <= dx2_in;
         d_dye2_ff <= dye2_in;
         d_dyo2_ff <= dyo2_in;
         e_pz_ff   <= d_pz_ff;
         e_col_ff  <= d_col_ff;
         e_row_ff  <= d_row_ff;
         e_cand_ff <= cand_in;
      end
   end

   assign out_valid = e_valid_ff;
   assign out_pz    = e_pz_ff;
   assign out_col   = e_col_ff;
   assign out_row   = e_row_ff;
   assign out_cand  = e_cand_ff;

endmodule

@@ design/hgp_sel.sv @@
// hgp_sel: picks the nearest hit among nine candidates and range-checks the winner.
// Depends on hgp_pkg; three register stages, the last is the response register.
module hgp_sel #(
   parameter int QN        = 30,
   parameter int CELL_BITS = hgp_pkg::CELL_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic                        in_pz,
   input  logic signed [QN:0]          in_col,
   input  logic signed [QN:0]          in_row,
   input  hgp_pkg::cand_type           in_cand [hgp_pkg::NCAND],
   output logic                        out_valid,
   output logic                        out_found,
   output logic signed [CELL_BITS-1:0] out_col,
   output logic signed [CELL_BITS-1:0] out_row
);
   import hgp_pkg::*;

   function automatic logic better(input cand_type b, input cand_type a);
      return b.hit && (!a.hit || (b.dsq < a.dsq));
   endfunction

   cand_type           f_best_in [3];
   logic [1:0]         f_kr_in   [3];
   logic               f_valid_ff, f_pz_ff;
   logic signed [QN:0] f_col_ff, f_row_ff;
   cand_type           f_best_ff [3];
   logic [1:0]         f_kr_ff   [3];

   logic               g_hit_in;
   logic [1:0]         g_kc_in, g_kr_in;
   logic               g_valid_ff, g_pz_ff, g_hit_ff;
   logic signed [QN:0] g_col_ff, g_row_ff;
   logic [1:0]         g_kc_ff, g_kr_ff;

   logic [QN+1:0]          col_w, row_w;
   logic                   found_in;
   logic [CELL_BITS-1:0]   col_in, row_in;
   logic                   h_valid_ff, h_found_ff;
   logic [CELL_BITS-1:0]   h_col_ff, h_row_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         f_best_in[c] = in_cand[3*c];
         f_kr_in[c]   = 2'd0;
         for (int r = 1; r < 3; r++) begin
            if (better(in_cand[3*c+r], f_best_in[c])) begin
               f_best_in[c] = in_cand[3*c+r];
               f_kr_in[c]   = 2'(r);
            end
         end
      end
   end

   always_comb begin
      cand_type best;
      best    = f_best_ff[0];
      g_kc_in = 2'd0;
      g_kr_in = f_kr_ff[0];
      for (int c = 1; c < 3; c++) begin
         if (better(f_best_ff[c], best)) begin
            best    = f_best_ff[c];
            g_kc_in = 2'(c);
            g_kr_in = f_kr_ff[c];
         end
      end
      g_hit_in = best.hit;
   end

   always_comb begin
      logic [QN+1-(CELL_BITS-1):0] hi_c, hi_r;
      logic                        fit_c, fit_r;
      col_w = {g_col_ff[QN], g_col_ff} + (QN+2)'(g_kc_ff) - (QN+2)'(1);
      row_w = {g_row_ff[QN], g_row_ff} + (QN+2)'(g_kr_ff) - (QN+2)'(1);
      hi_c  = col_w[QN+1:CELL_BITS-1];
      hi_r  = row_w[QN+1:CELL_BITS-1];
      fit_c = (&hi_c) || !(|hi_c);
      fit_r = (&hi_r) || !(|hi_r);
      found_in = g_hit_ff && !g_pz_ff && fit_c && fit_r;
      col_in   = found_in ? col_w[CELL_BITS-1:0] : '0;
      row_in   = found_in ? row_w[CELL_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= in_valid;
         g_valid_ff <= f_valid_ff;
         h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_pz_ff    <= in_pz;
         f_col_ff   <= in_col;
         f_row_ff   <= in_row;
         f_best_ff  <= f_best_in;
         f_kr_ff    <= f_kr_in;
         g_pz_ff    <= f_pz_ff;
         g_col_ff   <= f_col_ff;
         g_row_ff   <= f_row_ff;
         g_hit_ff   <= g_hit_in;
         g_kc_ff    <= g_kc_in;
         g_kr_ff    <= g_kr_in;
         h_found_ff <= found_in;
         h_col_ff   <= col_in;
         h_row_ff   <= row_in;
      end
   end

   assign out_valid = h_valid_ff;
   assign out_found = h_found_ff;
   assign out_col   = signed'(h_col_ff);
   assign out_row   = signed'(h_row_ff);

endmodule

@@ design/hex_grid_pick.sv @@
// Hex grid pick maps a pointer pixel position to the hex cell under it: it normalizes
// the point against the screen size, estimates a column and row, and tests the 3x3
// neighbor cells for the nearest center within the radius. One transaction is
// accepted per clock while the response side does not stall; the two pipelined
// dividers resolve one quotient bit per stage. A stalled response holds the whole
// pipeline. Write the configuration registers only while no transaction is in flight;
// derived pitch values settle through pitch_ff, then tri_ff and prod_ff, then hp_ff.
module hex_grid_pick #(
   parameter int FRAC_BITS = hgp_pkg::FRAC_BITS_DEF,
   parameter int CELL_BITS = hgp_pkg::CELL_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [hgp_pkg::IDX_W-1:0]  csr_index,
   input  logic [hgp_pkg::CSR_W-1:0]  csr_wdata,
   hgp_req_if.sink                    req_bus,
   hgp_rsp_if.source                  rsp_bus
);
   import hgp_pkg::*;

   localparam int QW     = PTR_W + 1 + FRAC_BITS;
   localparam int QN     = QW + 1;
   localparam int PROD_W = FRAC_BITS + 1 + PITCH_W;
   localparam longint SQRT3_FULL = sqrt3_fix(FRAC_BITS);
   localparam logic [FRAC_BITS:0] SQRT3_FIX = SQRT3_FULL[FRAC_BITS:0];
   localparam logic [PROD_W-1:0]  HALF_LSB  = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [QW:0]        ONE_Q     = (QW+1)'(1) << FRAC_BITS;
   localparam logic [QW+1:0]      TWO_Q     = (QW+2)'(1) << (FRAC_BITS + 1);

   logic [CSR_W-1:0]   radius_ff, gap_ff;
   logic [SCR_W-1:0]   width_ff, height_ff;
   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic [TRI_W-1:0]   tri_ff, tri_in;
   logic [PROD_W-1:0]  prod_ff, prod_in, prod_rnd;
   logic [HP_W-1:0]    hp_ff, hp_in;
   logic [LIM_W-1:0]   limit_ff, limit_in;
   logic [2*CSR_W-1:0] rad_sq;
   geo_type            geo;

   logic               en;
   logic [SCR_W-1:0]   width_eff, height_eff;
   logic               pitch_zero_in;

   logic               d1_valid, d1_sb;
   logic [QW-1:0]      d1_quo_x, d1_quo_y;
   logic [SCR_W-1:0]   d1_rem_x, d1_rem_y;

   logic [QW+1:0]      ax, ax_mag;
   logic [QW:0]        by, by_mag;
   div_sb_type         b_sb_in, b_sb_ff;
   logic [QN-1:0]      b_mag_x_in, b_mag_y_in, b_mag_x_ff, b_mag_y_ff;
   logic               b_valid_ff;

   logic               d2_valid;
   logic [QN-1:0]      d2_quo_x, d2_quo_y;
   logic [DIV_DW-1:0]  d2_rem_x, d2_rem_y;
   div_sb_type         d2_sb;

   logic               cd_valid, cd_pz;
   logic signed [QN:0] cd_col, cd_row;
   cand_type           cd_cand [NCAND];

   logic               sel_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         gap_ff    <= GAP_RST;
         width_ff  <= SCREEN_RST;
         height_ff <= SCREEN_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            REG_HEX_RADIUS: begin
               radius_ff <= csr_wdata;
            end
            REG_HEX_GAP: begin
               gap_ff <= csr_wdata;
            end
            REG_SCREEN_WIDTH: begin
               width_ff <= csr_wdata[SCR_W-1:0];
            end
            REG_SCREEN_HEIGHT: begin
               height_ff <= csr_wdata[SCR_W-1:0];
            end
            default: begin
               radius_ff <= radius_ff;
            end
         endcase
      end
   end

   assign pitch_in = {1'b0, radius_ff} + {1'b0, gap_ff};
   assign tri_in   = {1'b0, pitch_ff, 1'b0} + {2'b00, pitch_ff};
   assign prod_in  = PROD_W'(pitch_ff) * PROD_W'(SQRT3_FIX);
   assign prod_rnd = prod_ff + HALF_LSB;
   assign hp_in    = prod_rnd[FRAC_BITS +: HP_W];
   assign rad_sq   = (2*CSR_W)'(radius_ff) * (2*CSR_W)'(radius_ff);
   assign limit_in = {rad_sq, 2'b00};

   always_ff @(posedge clock) begin
      pitch_ff <= pitch_in;
      tri_ff   <= tri_in;
      prod_ff  <= prod_in;
      hp_ff    <= hp_in;
      limit_ff <= limit_in;
   end

   assign geo.tri_pitch = tri_ff;
   assign geo.row_pitch = hp_ff;
   assign geo.limit     = limit_ff;

   assign en            = !sel_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   assign width_eff     = (width_ff == '0) ? SCR_W'(1) : width_ff;
   assign height_eff    = (height_ff == '0) ? SCR_W'(1) : height_ff;
   assign pitch_zero_in = (radius_ff == '0) && (gap_ff == '0);

   hgp_div #(.NW(QW), .DW(SCR_W), .SW(1)) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_num_a  ({req_bus.pointer_x, 1'b0, {FRAC_BITS{1'b0}}}),
      .in_num_b  ({req_bus.pointer_y, 1'b0, {FRAC_BITS{1'b0}}}),
      .den_a     (width_eff),
      .den_b     (height_eff),
      .in_sb     (pitch_zero_in),
      .out_valid (d1_valid),
      .out_quo_a (d1_quo_x),
      .out_quo_b (d1_quo_y),
      .out_rem_a (d1_rem_x),
      .out_rem_b (d1_rem_y),
      .out_sb    (d1_sb)
   );

   always_comb begin
      ax         = {1'b0, d1_quo_x, 1'b0} - TWO_Q;
      ax_mag     = ax[QW+1] ? -ax : ax;
      by         = {1'b0, d1_quo_y} - ONE_Q;
      by_mag     = by[QW] ? -by : by;
      b_mag_x_in = ax_mag[QW:0];
      b_mag_y_in = {1'b0, by_mag[QW-1:0]};
      b_sb_in.pitch_zero = d1_sb;
      b_sb_in.neg_x      = ax[QW+1];
      b_sb_in.neg_y      = by[QW] ^ (|d1_rem_x & 1'b0) ^ (|d1_rem_y & 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= d1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_sb_ff    <= b_sb_in;
         b_mag_x_ff <= b_mag_x_in;
         b_mag_y_ff <= b_mag_y_in;
      end
   end

   hgp_div #(.NW(QN), .DW(DIV_DW), .SW($bits(div_sb_type))) u_cell_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_num_a  (b_mag_x_ff),
      .in_num_b  (b_mag_y_ff),
      .den_a     (geo.tri_pitch),
      .den_b     ({1'b0, geo.row_pitch}),
      .in_sb     (b_sb_ff),
      .out_valid (d2_valid),
      .out_quo_a (d2_quo_x),
      .out_quo_b (d2_quo_y),
      .out_rem_a (d2_rem_x),
      .out_rem_b (d2_rem_y),
      .out_sb    (d2_sb)
   );

   hgp_cand #(.QN(QN)) u_cand (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d2_valid),
      .quo_x     (d2_quo_x),
      .rem_x     (d2_rem_x),
      .quo_y     (d2_quo_y),
      .rem_y     (d2_rem_y),
      .in_sb     (d2_sb),
      .geo       (geo),
      .out_valid (cd_valid),
      .out_pz    (cd_pz),
      .out_col   (cd_col),
      .out_row   (cd_row),
      .out_cand  (cd_cand)
   );

   hgp_sel #(.QN(QN), .CELL_BITS(CELL_BITS)) u_sel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (cd_valid),
      .in_pz     (cd_pz),
      .in_col    (cd_col),
      .in_row    (cd_row),
      .in_cand   (cd_cand),
      .out_valid (sel_valid),
      .out_found (rsp_bus.found),
      .out_col   (rsp_bus.cell_col),
      .out_row   (rsp_bus.cell_row)
   );

   assign rsp_bus.valid = sel_valid;

endmodule

@@ design/hgp_chk.sv @@
// hgp_chk: port-level assertions for hex_grid_pick, attached by bind.
// Depends on hex_grid_pick's port list.
module hgp_chk #(
   parameter int CELL_BITS = hgp_pkg::CELL_BITS_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_found,
   input logic [CELL_BITS-1:0] rsp_col,
   input logic [CELL_BITS-1:0] rsp_row
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found)
                                  && $stable(rsp_col) && $stable(rsp_row))
      else $error("stalled response transaction changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_col == '0) && (rsp_row == '0))
      else $error("miss response carries a nonzero cell");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled while response side is empty");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request accepted while pipeline is stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind hex_grid_pick hgp_chk #(.CELL_BITS(CELL_BITS)) u_hgp_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_found (rsp_bus.found),
   .rsp_col   (rsp_bus.cell_col),
   .rsp_row   (rsp_bus.cell_row)
);
